### src/msa_pkg.sv
// package for the moment sum accumulator
// types and constants shared by all modules, and the controller states
package msa_pkg;

  localparam int unsigned NumQty   = 16;
  localparam int unsigned IdxW     = 4;
  localparam int unsigned ValW     = 12;
  localparam int unsigned CntW     = 5;

  localparam logic [ValW-1:0] MinInit = 12'sd2047;
  localparam logic [ValW-1:0] MaxInit = 12'h800;
  localparam logic [ValW-1:0] OneQ38  = 12'd256;

  localparam logic ReqAdd  = 1'b0;
  localparam logic ReqRead = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_MUL2,
    ST_WRITE,
    ST_OUT
  } msa_state_t;

  typedef struct packed {
    logic load;
    logic read;
    logic mul;
    logic mul2;
    logic write;
  } msa_cmd_t;

  typedef struct packed {
    logic idx_err;
  } msa_stat_t;

  typedef struct packed {
    logic              req_type;
    logic              run_success;
    logic [IdxW-1:0]   quantity_index;
    logic signed [ValW-1:0] sample_value;
    logic              run_last;
  } msa_in_t;

  typedef struct packed {
    logic [IdxW-1:0]        entry_index;
    logic signed [63:0]     sum_first;
    logic [62:0]            sum_second;
    logic signed [63:0]     sum_third;
    logic [62:0]            sum_fourth;
    logic signed [ValW-1:0] least_seen;
    logic signed [ValW-1:0] greatest_seen;
    logic                   only_zero_one;
    logic [31:0]            runs_total;
    logic [31:0]            runs_succeeded;
    logic                   index_error;
  } msa_out_t;

endpackage

### src/msa_if.sv
// valid/ready channel interfaces for input, result and config words
// depends on msa_pkg
interface msa_in_if;
  logic valid;
  logic ready;
  msa_pkg::msa_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface msa_out_if;
  logic valid;
  logic ready;
  msa_pkg::msa_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface msa_cfg_if;
  logic valid;
  logic ready;
  logic [msa_pkg::CntW-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/moment_sum_accumulator.sv
// channel   | dir | payload
// in_       | in  | msa_in_t: request, success, index, Q3.8 value, last
// out_      | out | msa_out_t: entry sums, min, max, flag, run counts, error
// cfg_      | in  | active count, 5 bits
// an item goes from acceptance to result through index check and square,
// cube, fourth power, saturating write-back, then the result word; a
// waiting result accepts the next word in the same cycle it is taken; an
// out-of-range index goes from the check straight to the result word
// rst_n is synchronous; it clears all sums, counters and sets active count 16
module moment_sum_accumulator (
  input logic       clk,
  input logic       rst_n,
  msa_in_if.sink    in_ch,
  msa_out_if.source out_ch,
  msa_cfg_if.sink   cfg_ch
);
  import msa_pkg::*;

  msa_cmd_t  cmd;
  msa_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  msa_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .stat, .cmd
  );

  msa_dp u_dp (
    .clk, .rst_n, .cmd, .stat,
    .in_data(in_ch.data),
    .cfg_we(cfg_ch.valid), .cfg_data(cfg_ch.data),
    .out_data(out_ch.data)
  );

endmodule

### src/msa_ctrl.sv
// controller state machine for the moment sum accumulator
// depends on msa_pkg
module msa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  msa_pkg::msa_stat_t stat,
  output msa_pkg::msa_cmd_t  cmd
);
  import msa_pkg::*;

  msa_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_READ;
      ST_READ:  state_nxt = stat.idx_err ? ST_OUT : ST_MUL;
      ST_MUL:   state_nxt = ST_MUL2;
      ST_MUL2:  state_nxt = ST_WRITE;
      ST_WRITE: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_ready) begin
          state_nxt = in_valid ? ST_READ : ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_READ:  cmd.read  = 1'b1;
      ST_MUL:   cmd.mul   = 1'b1;
      ST_MUL2:  cmd.mul2  = 1'b1;
      ST_WRITE: cmd.write = 1'b1;
      ST_OUT: begin
        out_valid = 1'b1;
        in_ready  = out_ready;
        cmd.load  = out_ready & in_valid;
      end
      default: ;
    endcase
  end

endmodule

### src/msa_dp.sv
// datapath: entry store, power products, saturating sums, run counters
// depends on msa_pkg
module msa_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  msa_pkg::msa_cmd_t      cmd,
  output msa_pkg::msa_stat_t     stat,
  input  msa_pkg::msa_in_t       in_data,
  input  logic                   cfg_we,
  input  logic [msa_pkg::CntW-1:0] cfg_data,
  output msa_pkg::msa_out_t      out_data
);
  import msa_pkg::*;

  logic [CntW-1:0] active_r;
  msa_in_t         item_r;
  logic signed [63:0] s1_r [NumQty];
  logic signed [63:0] s2_r [NumQty];
  logic signed [63:0] s3_r [NumQty];
  logic signed [63:0] s4_r [NumQty];
  logic signed [ValW-1:0] mn_r [NumQty];
  logic signed [ValW-1:0] mx_r [NumQty];
  logic [NumQty-1:0] bin_r;
  logic [31:0] runs_r, succ_r;
  logic err_r;
  logic signed [23:0] p2_r;
  logic signed [35:0] p3_r;
  logic signed [47:0] p4_r;
  logic signed [63:0] a1, a2, a3, a4, n1, n2, n3, n4;
  logic upd;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s;
  endfunction

  assign stat.idx_err = ({1'b0, item_r.quantity_index} >= active_r);
  assign upd = (item_r.req_type == ReqAdd) && !err_r;

  always_comb begin
    a1 = s1_r[item_r.quantity_index];
    a2 = s2_r[item_r.quantity_index];
    a3 = s3_r[item_r.quantity_index];
    a4 = s4_r[item_r.quantity_index];
    n1 = sat_add(a1, 64'(item_r.sample_value));
    n2 = sat_add(a2, 64'(p2_r));
    n3 = sat_add(a3, 64'(p3_r));
    n4 = sat_add(a4, 64'(p4_r));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;
    if (cmd.read) begin
      err_r <= ({1'b0, item_r.quantity_index} >= active_r);
      p2_r  <= item_r.sample_value * item_r.sample_value;
    end
    if (cmd.mul) begin
      p3_r <= p2_r * item_r.sample_value;
    end
    if (cmd.mul2) begin
      p4_r <= p2_r * p2_r;
    end
    if (!rst_n) begin
      active_r <= CntW'(NumQty);
      runs_r   <= '0;
      succ_r   <= '0;
      bin_r    <= '1;
      for (int k = 0; k < NumQty; k++) begin
        s1_r[k] <= '0; s2_r[k] <= '0; s3_r[k] <= '0; s4_r[k] <= '0;
        mn_r[k] <= MinInit; mx_r[k] <= MaxInit;
      end
    end else begin
      if (cfg_we) active_r <= cfg_data;
      if (cmd.write && upd) begin
        if (item_r.run_success) begin
          s1_r[item_r.quantity_index] <= n1;
          s2_r[item_r.quantity_index] <= n2;
          s3_r[item_r.quantity_index] <= n3;
          s4_r[item_r.quantity_index] <= n4;
          if (item_r.sample_value < mn_r[item_r.quantity_index])
            mn_r[item_r.quantity_index] <= item_r.sample_value;
          if (item_r.sample_value > mx_r[item_r.quantity_index])
            mx_r[item_r.quantity_index] <= item_r.sample_value;
          if (item_r.sample_value != '0 && item_r.sample_value != OneQ38)
            bin_r[item_r.quantity_index] <= 1'b0;
        end
        if (item_r.run_last) begin
          if (runs_r != '1) runs_r <= runs_r + 32'd1;
          if (item_r.run_success && succ_r != '1) succ_r <= succ_r + 32'd1;
        end
      end
    end
  end

  always_comb begin
    out_data = '0;
    out_data.entry_index    = item_r.quantity_index;
    out_data.runs_total     = runs_r;
    out_data.runs_succeeded = succ_r;
    out_data.index_error    = err_r;
    if (!err_r) begin
      out_data.sum_first     = s1_r[item_r.quantity_index];
      out_data.sum_second    = s2_r[item_r.quantity_index][62:0];
      out_data.sum_third     = s3_r[item_r.quantity_index];
      out_data.sum_fourth    = s4_r[item_r.quantity_index][62:0];
      out_data.least_seen    = mn_r[item_r.quantity_index];
      out_data.greatest_seen = mx_r[item_r.quantity_index];
      out_data.only_zero_one = bin_r[item_r.quantity_index];
    end
  end

endmodule

### src/msa_checker.sv
// port-level checks for the moment sum accumulator
// depends on msa_pkg; bound to moment_sum_accumulator
module msa_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input msa_pkg::msa_out_t out_data
);
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("result changed");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready) else $error("accept while stalled");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.index_error |-> out_data.sum_first == 64'd0 &&
    out_data.only_zero_one == 1'b0) else $error("error word not cleared");
  a_succ_le: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.runs_succeeded <= out_data.runs_total) else $error("counts");
endmodule

bind moment_sum_accumulator msa_checker u_chk (
  .clk, .rst_n,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_data(out_ch.data)
);

### tb/moment_sum_accumulator_tb.sv
// self-checking testbench for moment_sum_accumulator: directed table, then random words
// uses msa_pkg, the channel interfaces in src/msa_if.sv and the rtl top level
module moment_sum_accumulator_tb;
  import msa_pkg::*;

  logic clk;
  logic rst_n;

  msa_in_if  in_ch ();
  msa_out_if out_ch ();
  msa_cfg_if cfg_ch ();

  moment_sum_accumulator u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  localparam logic signed [63:0] SumHi = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [63:0] SumLo = 64'sh8000_0000_0000_0000;
  localparam int DirN = 22;

  // predictor state
  logic signed [63:0] pow1_q [NumQty];
  logic signed [63:0] pow2_q [NumQty];
  logic signed [63:0] pow3_q [NumQty];
  logic signed [63:0] pow4_q [NumQty];
  logic signed [ValW-1:0] min_q [NumQty];
  logic signed [ValW-1:0] max_q [NumQty];
  logic bin_q [NumQty];
  logic [31:0] runs_q;
  logic [31:0] wins_q;
  logic [CntW-1:0] active_q;

  msa_out_t entry_fifo [$];
  int errors;
  int rx_count;
  bit long_hold;

  typedef struct {
    msa_in_t word;
    bit      typed;
    msa_out_t want;
  } dir_row_t;
  dir_row_t dir_rows [DirN];

  function automatic logic signed [63:0] sat_sum(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > 65'sh0_7fff_ffff_ffff_ffff) return SumHi;
    if (s < -65'sh0_8000_0000_0000_0000) return SumLo;
    return s[63:0];
  endfunction

  function automatic msa_out_t predict_entry(msa_in_t w);
    msa_out_t r;
    logic signed [63:0] v, p2, p3, p4;
    int i;
    r = '0;
    i = w.quantity_index;
    r.entry_index = w.quantity_index;
    if (w.quantity_index >= active_q) begin
      r.runs_total = runs_q;
      r.runs_succeeded = wins_q;
      r.index_error = 1'b1;
      return r;
    end
    if (w.req_type == ReqAdd) begin
      if (w.run_success) begin
        v = w.sample_value;
        p2 = v * v;
        p3 = p2 * v;
        p4 = p2 * p2;
        pow1_q[i] = sat_sum(pow1_q[i], v);
        pow2_q[i] = sat_sum(pow2_q[i], p2);
        pow3_q[i] = sat_sum(pow3_q[i], p3);
        pow4_q[i] = sat_sum(pow4_q[i], p4);
        if (w.sample_value < min_q[i]) min_q[i] = w.sample_value;
        if (w.sample_value > max_q[i]) max_q[i] = w.sample_value;
        if (w.sample_value != 0 && w.sample_value != OneQ38) bin_q[i] = 1'b0;
      end
      if (w.run_last) begin
        if (runs_q != '1) runs_q = runs_q + 1;
        if (w.run_success && wins_q != '1) wins_q = wins_q + 1;
      end
    end
    r.sum_first = pow1_q[i];
    r.sum_second = pow2_q[i][62:0];
    r.sum_third = pow3_q[i];
    r.sum_fourth = pow4_q[i][62:0];
    r.least_seen = min_q[i];
    r.greatest_seen = max_q[i];
    r.only_zero_one = bin_q[i];
    r.runs_total = runs_q;
    r.runs_succeeded = wins_q;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic msa_in_t make_word(bit rq, bit sc, int idx, int val, bit lst);
    msa_in_t w;
    w.req_type = rq;
    w.run_success = sc;
    w.quantity_index = IdxW'(idx);
    w.sample_value = ValW'(val);
    w.run_last = lst;
    return w;
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("FAIL");
    $finish;
  end

  // result side: random stalls, plus one long hold-off
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (60) @(posedge clk);
        long_hold = 1'b0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk iff out_ch.valid);
    end
  end

  always @(posedge clk) begin
    msa_out_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      rx_count++;
      if (entry_fifo.size() == 0) begin
        report_mismatch("unexpected word", got.entry_index, 0);
      end else begin
        want = entry_fifo.pop_front();
        if (got.entry_index !== want.entry_index)
          report_mismatch("entry_index", got.entry_index, want.entry_index);
        if (got.sum_first !== want.sum_first)
          report_mismatch("sum_first", got.sum_first, want.sum_first);
        if (got.sum_second !== want.sum_second)
          report_mismatch("sum_second", got.sum_second, want.sum_second);
        if (got.sum_third !== want.sum_third)
          report_mismatch("sum_third", got.sum_third, want.sum_third);
        if (got.sum_fourth !== want.sum_fourth)
          report_mismatch("sum_fourth", got.sum_fourth, want.sum_fourth);
        if (got.least_seen !== want.least_seen)
          report_mismatch("least_seen", got.least_seen, want.least_seen);
        if (got.greatest_seen !== want.greatest_seen)
          report_mismatch("greatest_seen", got.greatest_seen, want.greatest_seen);
        if (got.only_zero_one !== want.only_zero_one)
          report_mismatch("only_zero_one", got.only_zero_one, want.only_zero_one);
        if (got.runs_total !== want.runs_total)
          report_mismatch("runs_total", got.runs_total, want.runs_total);
        if (got.runs_succeeded !== want.runs_succeeded)
          report_mismatch("runs_succeeded", got.runs_succeeded, want.runs_succeeded);
        if (got.index_error !== want.index_error)
          report_mismatch("index_error", got.index_error, want.index_error);
      end
    end
  end

  task automatic send_word(msa_in_t w, bit gaps);
    int gap;
    gap = gaps ? (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14)) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    @(posedge clk iff in_ch.ready);
    entry_fifo.push_back(predict_entry(w));
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (entry_fifo.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_active(logic [CntW-1:0] n);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= n;
    @(posedge clk iff cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    active_q = n;
  endtask

  task automatic random_words(int n, int idx_hi, bit big_vals);
    msa_in_t w;
    int k;
    for (k = 0; k < n; k++) begin
      w = make_word($urandom_range(0, 5) == 0, $urandom_range(0, 4) != 0,
                    $urandom_range(0, idx_hi), 0, $urandom_range(0, 3) == 0);
      case ($urandom_range(0, 5))
        0: w.sample_value = big_vals ? 12'h7ff : 12'h100;
        1: w.sample_value = big_vals ? 12'h800 : 12'h000;
        default: w.sample_value = ValW'($urandom);
      endcase
      send_word(w, 1'b1);
    end
  endtask

  initial begin
    int k;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    errors = 0;
    rx_count = 0;
    long_hold = 1'b0;
    for (k = 0; k < NumQty; k++) begin
      pow1_q[k] = 0; pow2_q[k] = 0; pow3_q[k] = 0; pow4_q[k] = 0;
      min_q[k] = MinInit; max_q[k] = MaxInit; bin_q[k] = 1'b1;
    end
    runs_q = 0;
    wins_q = 0;
    active_q = 16;
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table; typed rows carry obvious answers
    for (k = 0; k < DirN; k++) dir_rows[k].typed = 1'b0;
    dir_rows[0].word = make_word(ReqRead, 0, 0, 0, 0);
    dir_rows[0].typed = 1'b1;
    dir_rows[0].want = '0;
    dir_rows[0].want.least_seen = MinInit;
    dir_rows[0].want.greatest_seen = MaxInit;
    dir_rows[0].want.only_zero_one = 1'b1;
    dir_rows[1].word = make_word(ReqAdd, 1, 1, 0, 0);
    dir_rows[2].word = make_word(ReqAdd, 1, 1, 256, 1);
    dir_rows[3].word = make_word(ReqAdd, 1, 2, 2047, 0);
    dir_rows[4].word = make_word(ReqAdd, 1, 2, -2048, 1);
    dir_rows[5].word = make_word(ReqAdd, 0, 3, 1000, 0);
    dir_rows[6].word = make_word(ReqAdd, 0, 3, -5, 1);
    dir_rows[7].word = make_word(ReqRead, 1, 3, 77, 1);
    dir_rows[8].word = make_word(ReqAdd, 1, 15, -1, 1);
    dir_rows[9].word = make_word(ReqAdd, 1, 15, 1, 0);
    dir_rows[10].word = make_word(ReqRead, 0, 1, 0, 0);
    dir_rows[11].word = make_word(ReqAdd, 1, 4, 255, 0);
    dir_rows[12].word = make_word(ReqAdd, 1, 4, 257, 1);
    dir_rows[13].word = make_word(ReqRead, 0, 2, 0, 0);
    for (k = 14; k < DirN; k++)
      dir_rows[k].word = make_word(ReqAdd, 1, 5, (k & 1) ? -2048 : 2047, k & 1);
    for (k = 0; k < DirN; k++) begin
      send_word(dir_rows[k].word, 1'b0);
      if (dir_rows[k].typed) entry_fifo[$] = dir_rows[k].want;
    end
    drain_results();

    // index at and beyond the active count, including zero
    write_active(1);
    send_word(make_word(ReqAdd, 1, 1, 5, 1), 1'b0);
    entry_fifo[$] = '{entry_index: 4'd1, runs_total: runs_q, runs_succeeded: wins_q,
                      index_error: 1'b1, default: '0};
    send_word(make_word(ReqAdd, 1, 0, 5, 1), 1'b0);
    drain_results();
    write_active(0);
    send_word(make_word(ReqRead, 0, 0, 0, 0), 1'b0);
    send_word(make_word(ReqAdd, 1, 15, 3, 1), 1'b0);
    drain_results();
    write_active(31);
    random_words(200, 15, 1'b0);

    // receiver holds off while the sender keeps pushing
    long_hold = 1'b1;
    random_words(40, 15, 1'b0);
    drain_results();

    write_active(5);
    random_words(200, 15, 1'b0);
    drain_results();
    write_active(16);
    random_words(200, 15, 1'b0);
    drain_results();

    // grind entries 0 and 1 toward the fourth-power ceiling, mixing in extreme values
    write_active(2);
    random_words(150, 1, 1'b1);
    drain_results();

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

### filelist.f
src/msa_pkg.sv
src/msa_if.sv
src/msa_ctrl.sv
src/msa_dp.sv
src/moment_sum_accumulator.sv
src/msa_checker.sv
tb/moment_sum_accumulator_tb.sv
